>>> rtl/core/swnd_pkg.sv
// ----------------------------------------------------------------------------
// swnd_pkg
// Shared widths and codes for the sliding-window sender.
// ----------------------------------------------------------------------------
`default_nettype none

package swnd_pkg;

	// Sequence space width; sequences wrap modulo 2^SEQ_W
	localparam int SEQ_W = 32;

	// Field widths
	localparam int CMD_W    = 2;
	localparam int ACT_W    = 3;
	localparam int WND_W    = 16;
	localparam int RTO_W    = 20;
	localparam int RETRY_W  = 8;
	localparam int DUP_W    = 3;
	localparam int CNT_W    = 32;
	localparam int FIELD_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 20;

	// Packed stream widths
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 208;

	// Event commands
	localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

	// Result actions
	localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_TX_NEW  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TIMEOUT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FAST    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ABORT   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_REFUSED = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENDER_WND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECV_WND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RTO        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRY  = 2'd3;

	// Reset values
	localparam logic [WND_W-1:0]   SENDER_WND_RST = 16'd16;
	localparam logic [WND_W-1:0]   RECV_WND_RST   = 16'd16;
	localparam logic [RTO_W-1:0]   RTO_RST        = 20'd1000;
	localparam logic [RETRY_W-1:0] MAX_RETRY_RST  = 8'd50;

	// Duplicate ACK count that fires a fast retransmit, and its ceiling
	localparam logic [DUP_W-1:0] DUP_TRIGGER = 3'd3;
	localparam logic [DUP_W-1:0] DUP_MAX     = 3'd4;
	localparam logic [RETRY_W-1:0] RETRY_MAX = 8'd255;

endpackage

`default_nettype wire

>>> rtl/core/sliding_window_sender.sv
// ----------------------------------------------------------------------------
// sliding_window_sender
// Sender side of a sliding window with timeout and fast retransmit.
// ----------------------------------------------------------------------------
// Takes one event per clock while the result side keeps up (send request,
// cumulative ACK or time tick) and returns one result per event. An accepted
// event sits in an input register, the window state is updated from it in a
// single pass of compares and adds, and the result lands in an output register
// and is held there until the sink takes it. The sustained rate is one event
// per cycle while the result stream is not stalled, set by the
// single state-update stage. The output register decouples the sides, so one
// more event is taken into the input register while a result still waits.
// Register writes are taken at once and are meant for idle periods only;
// writing either window register reloads the window and the release limit.
`default_nettype none

module sliding_window_sender (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Event stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [swnd_pkg::S_TDATA_W-1:0]  s_tdata,  // ack_seq[31:0], recv_wnd[47:32]
	input  wire logic [swnd_pkg::CMD_W-1:0]      s_tuser,  // cmd[1:0]
	// Result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// tx_seq[31:0], base_now[63:32], next_now[95:64], window_now[111:96],
	// timeouts_now[143:112], fast_retx_now[175:144], acked_now[207:176]
	output logic [swnd_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [swnd_pkg::ACT_W-1:0]           m_tuser,  // action[2:0]
	// Register writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [swnd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swnd_pkg::CFG_DAT_W-1:0]  cfg_data
);

	localparam int SW = swnd_pkg::SEQ_W;
	localparam int WW = swnd_pkg::WND_W;
	localparam int RW = swnd_pkg::RTO_W;
	localparam int TW = swnd_pkg::RETRY_W;
	localparam int DW = swnd_pkg::DUP_W;
	localparam int CW = swnd_pkg::CNT_W;

	function automatic logic [WW-1:0] min_wnd(input logic [WW-1:0] a, input logic [WW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [RW-1:0] rto_load(input logic [RW-1:0] r);
		return (r == '0) ? RW'(1) : r;
	endfunction

	// Configuration registers
	logic [WW-1:0] sender_wnd_q;
	logic [WW-1:0] init_rwnd_q;
	logic [RW-1:0] rto_q;
	logic [TW-1:0] max_retry_q;

	// Window state
	logic [SW-1:0] base_q, next_q, limit_q;
	logic [WW-1:0] wnd_q;
	logic [TW-1:0] retry_q;
	logic [DW-1:0] dup_q;
	logic [RW-1:0] timer_q;
	logic [CW-1:0] timeouts_q, fast_q, acked_q;
	logic          aborted_q;

	// Input stage
	logic                       valid_s1;
	logic [swnd_pkg::CMD_W-1:0] cmd_s1;
	logic [SW-1:0]              ack_s1;
	logic [WW-1:0]              rwnd_s1;

	// Output stage
	logic                       out_valid_q;
	logic [swnd_pkg::ACT_W-1:0] act_q;
	logic [SW-1:0]              tx_q;

	logic advance;
	logic cfg_fire;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Next state for the item in the input stage
	logic [SW-1:0]              n_base, n_next, n_limit, n_tx;
	logic [WW-1:0]              n_wnd;
	logic [TW-1:0]              n_retry;
	logic [DW-1:0]              n_dup;
	logic [RW-1:0]              n_timer;
	logic [CW-1:0]              n_timeouts, n_fast, n_acked;
	logic                       n_aborted;
	logic [swnd_pkg::ACT_W-1:0] n_act;
	logic [SW-1:0]              outstanding, room, ack_dist;
	logic [TW-1:0]              retry_inc;
	logic [DW-1:0]              dup_inc;

	always_comb begin
		n_base     = base_q;
		n_next     = next_q;
		n_limit    = limit_q;
		n_wnd      = wnd_q;
		n_retry    = retry_q;
		n_dup      = dup_q;
		n_timer    = timer_q;
		n_timeouts = timeouts_q;
		n_fast     = fast_q;
		n_acked    = acked_q;
		n_aborted  = aborted_q;
		n_act      = swnd_pkg::ACT_NONE;
		n_tx       = '0;
		outstanding = next_q - base_q;
		room        = limit_q - base_q;
		ack_dist    = ack_s1 - base_q;
		retry_inc   = (retry_q < swnd_pkg::RETRY_MAX) ? retry_q + TW'(1) : retry_q;
		dup_inc     = (dup_q < swnd_pkg::DUP_MAX) ? dup_q + DW'(1) : dup_q;

		if (aborted_q) begin
			n_act = swnd_pkg::ACT_ABORT;
		end else begin
			case (cmd_s1)
				swnd_pkg::CMD_SEND: begin
					if (outstanding < room) begin
						if (outstanding == '0) begin
							n_timer = rto_load(rto_q);
						end
						n_act  = swnd_pkg::ACT_TX_NEW;
						n_tx   = next_q;
						n_next = next_q + SW'(1);
					end else begin
						n_act = swnd_pkg::ACT_REFUSED;
					end
				end
				swnd_pkg::CMD_ACK: begin
					if (ack_dist != '0 && ack_dist <= outstanding) begin
						// New ACK: slide the window forward
						n_acked = acked_q + CW'(ack_dist);
						n_base  = ack_s1;
						n_timer = rto_load(rto_q);
						n_wnd   = min_wnd(sender_wnd_q, rwnd_s1);
						n_limit = ack_s1 + SW'(min_wnd(sender_wnd_q, rwnd_s1));
						n_retry = '0;
						n_dup   = '0;
					end else if (ack_dist == '0 && outstanding != '0) begin
						// Duplicate ACK: the third one fast-retransmits
						n_dup = dup_inc;
						if (dup_inc == swnd_pkg::DUP_TRIGGER) begin
							n_act   = swnd_pkg::ACT_FAST;
							n_tx    = base_q;
							n_timer = rto_load(rto_q);
							n_fast  = fast_q + CW'(1);
							n_retry = retry_inc;
						end
					end
				end
				swnd_pkg::CMD_TICK: begin
					if (outstanding != '0) begin
						if (timer_q > RW'(1)) begin
							n_timer = timer_q - RW'(1);
						end else begin
							n_retry    = retry_inc;
							n_timeouts = timeouts_q + CW'(1);
							if (retry_inc >= max_retry_q) begin
								n_aborted = 1'b1;
								n_act     = swnd_pkg::ACT_ABORT;
								n_timer   = '0;
							end else begin
								n_act   = swnd_pkg::ACT_TIMEOUT;
								n_tx    = base_q;
								n_timer = rto_load(rto_q);
							end
						end
					end
				end
				default: begin
					n_act = swnd_pkg::ACT_NONE;
				end
			endcase
		end
	end

	// Capture an accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			ack_s1  <= SW'(s_tdata[31:0]);
			rwnd_s1 <= s_tdata[47:32];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sender_wnd_q <= swnd_pkg::SENDER_WND_RST;
			init_rwnd_q  <= swnd_pkg::RECV_WND_RST;
			rto_q        <= swnd_pkg::RTO_RST;
			max_retry_q  <= swnd_pkg::MAX_RETRY_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				swnd_pkg::REG_SENDER_WND: sender_wnd_q <= cfg_data[WW-1:0];
				swnd_pkg::REG_RECV_WND:   init_rwnd_q  <= cfg_data[WW-1:0];
				swnd_pkg::REG_RTO:        rto_q        <= cfg_data[RW-1:0];
				swnd_pkg::REG_MAX_RETRY:  max_retry_q  <= cfg_data[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Window reload value on a window register write
	logic [WW-1:0] reload_wnd;

	always_comb begin
		case (cfg_index)
			swnd_pkg::REG_SENDER_WND: reload_wnd = min_wnd(cfg_data[WW-1:0], init_rwnd_q);
			swnd_pkg::REG_RECV_WND:   reload_wnd = min_wnd(sender_wnd_q, cfg_data[WW-1:0]);
			default:                  reload_wnd = wnd_q;
		endcase
	end

	// Advance the window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			next_q     <= '0;
			limit_q    <= SW'(min_wnd(swnd_pkg::SENDER_WND_RST, swnd_pkg::RECV_WND_RST));
			wnd_q      <= min_wnd(swnd_pkg::SENDER_WND_RST, swnd_pkg::RECV_WND_RST);
			retry_q    <= '0;
			dup_q      <= '0;
			timer_q    <= swnd_pkg::RTO_RST;
			timeouts_q <= '0;
			fast_q     <= '0;
			acked_q    <= '0;
			aborted_q  <= 1'b0;
		end else if (advance) begin
			base_q     <= n_base;
			next_q     <= n_next;
			limit_q    <= n_limit;
			wnd_q      <= n_wnd;
			retry_q    <= n_retry;
			dup_q      <= n_dup;
			timer_q    <= n_timer;
			timeouts_q <= n_timeouts;
			fast_q     <= n_fast;
			acked_q    <= n_acked;
			aborted_q  <= n_aborted;
		end else if (cfg_fire && (cfg_index == swnd_pkg::REG_SENDER_WND ||
				cfg_index == swnd_pkg::REG_RECV_WND)) begin
			wnd_q   <= reload_wnd;
			limit_q <= base_q + SW'(reload_wnd);
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [swnd_pkg::FIELD_W-1:0] tx_out, base_out, next_out;
	logic [WW-1:0]                wnd_out;
	logic [CW-1:0]                timeouts_out, fast_out, acked_out;

	always_ff @(posedge clk) begin
		if (advance) begin
			act_q        <= n_act;
			tx_q         <= n_tx;
			base_out     <= swnd_pkg::FIELD_W'(n_base);
			next_out     <= swnd_pkg::FIELD_W'(n_next);
			wnd_out      <= n_wnd;
			timeouts_out <= n_timeouts;
			fast_out     <= n_fast;
			acked_out    <= n_acked;
		end
	end

	assign tx_out   = swnd_pkg::FIELD_W'(tx_q);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = act_q;
	assign m_tdata  = {acked_out, fast_out, timeouts_out, wnd_out, next_out, base_out, tx_out};

	// An abort is sticky until reset
	a_abort_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		aborted_q |=> aborted_q)
		else $error("abort flag cleared without reset");

	// Once aborted, every produced result reports abort
	a_abort_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && aborted_q) |=> (m_tuser == swnd_pkg::ACT_ABORT))
		else $error("result after abort is not an abort");

	// The timer never sits at zero while the connection is alive
	a_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		!aborted_q |-> (timer_q != '0))
		else $error("retransmission timer at zero while running");

	// The duplicate ACK count saturates
	a_dup_sat: assert property (@(posedge clk) disable iff (!arst_n)
		dup_q <= swnd_pkg::DUP_MAX)
		else $error("duplicate ACK count past its ceiling");

endmodule

`default_nettype wire

>>> tb/sv/tb_sliding_window_sender.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_sender
// Self-checking bench for the sliding-window sender.
// ----------------------------------------------------------------------------
// Events (send, cumulative ACK, tick) go in through the slave stream from a
// queue. Each accepted event runs through an in-bench window model, and the
// predicted result is queued. The master stream is checked field by field
// against the oldest prediction. A directed opening covers the corner cases.
// Random phases under different window, timeout and retry settings follow.
// The closing phase drives the sender into abort and writes registers after it.
// A second copy of the model state plans well-formed ACKs and keeps the
// middle phases clear of abort. Both streams stall in random bursts.
// ----------------------------------------------------------------------------

module tb_sliding_window_sender;
	timeunit 1ns;
	timeprecision 1ps;

	import swnd_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned PHASE_EVENTS = 210;
	localparam int NUM_PHASES = 7;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [SEQ_W-1:0] ack_seq;
		logic [WND_W-1:0] recv_wnd;
	} event_t;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [SEQ_W-1:0] tx_seq, base_now, next_now;
		logic [WND_W-1:0] window_now;
		logic [CNT_W-1:0] timeouts_now, fast_retx_now, acked_now;
	} win_result_t;

	typedef struct {
		logic [WND_W-1:0]   sender_wnd, recv_wnd_init;
		logic [RTO_W-1:0]   rto;
		logic [RETRY_W-1:0] max_retry;
		logic [SEQ_W-1:0]   base_seq, next_seq, limit;
		logic [WND_W-1:0]   window;
		logic [RETRY_W-1:0] retries;
		logic [DUP_W-1:0]   dups;
		logic [RTO_W-1:0]   timer;
		logic [CNT_W-1:0]   timeouts, fast_retx, acked;
		logic               aborted;
	} win_state_t;

	// Register settings of the random phases: sender window, receiver window,
	// timeout, retry limit. Phase 4 is drawn at random instead.
	logic [CFG_DAT_W-1:0] phase_sw[NUM_PHASES]  = '{16, 65535, 1, 4, 0, 8, 0};
	logic [CFG_DAT_W-1:0] phase_rw[NUM_PHASES]  = '{16, 65535, 0, 8, 0, 65535, 16};
	logic [CFG_DAT_W-1:0] phase_rto[NUM_PHASES] = '{4, 1, 0, 7, 0, 1048575, 3};
	logic [CFG_DAT_W-1:0] phase_mr[NUM_PHASES]  = '{255, 200, 255, 3, 0, 50, 255};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // ack_seq[31:0], recv_wnd[47:32]
	logic [CMD_W-1:0] s_tuser = '0;       // cmd[1:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	// tx_seq[31:0], base_now[63:32], next_now[95:64], window_now[111:96],
	// timeouts_now[143:112], fast_retx_now[175:144], acked_now[207:176]
	logic [M_TDATA_W-1:0] m_tdata;
	logic [ACT_W-1:0] m_tuser;            // action[2:0]
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	event_t event_q[$];
	win_result_t expected_results[$];
	win_state_t model_st, plan_st;
	event_t held_event;
	logic event_held = 1'b0;
	logic quiet = 1'b0;
	logic allow_abort = 1'b0;
	int unsigned src_gap = 0, sink_stall = 0, stall_cycles = 0;
	int unsigned mismatches = 0, results_checked = 0, events_accepted = 0;
	int unsigned events_planned = 0, cfg_writes = 0;
	int unsigned action_seen[8] = '{default: 0};

	sliding_window_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5ns clk = ~clk;

	// ---------------- window model ----------------

	function automatic win_state_t reset_state();
		win_state_t st;
		st.sender_wnd = SENDER_WND_RST;
		st.recv_wnd_init = RECV_WND_RST;
		st.rto = RTO_RST;
		st.max_retry = MAX_RETRY_RST;
		st.base_seq = '0;
		st.next_seq = '0;
		st.window = (st.sender_wnd < st.recv_wnd_init) ? st.sender_wnd : st.recv_wnd_init;
		st.limit = st.base_seq + SEQ_W'(st.window);
		st.retries = '0;
		st.dups = '0;
		st.timer = st.rto;
		st.timeouts = '0;
		st.fast_retx = '0;
		st.acked = '0;
		st.aborted = 1'b0;
		return st;
	endfunction

	// A zero timeout still expires on the next tick
	function automatic logic [RTO_W-1:0] timer_load(input win_state_t st);
		return (st.rto == '0) ? RTO_W'(1) : st.rto;
	endfunction

	function automatic void apply_reg(inout win_state_t st, input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		case (idx)
		REG_SENDER_WND: st.sender_wnd = data[WND_W-1:0];
		REG_RECV_WND:   st.recv_wnd_init = data[WND_W-1:0];
		REG_RTO:        st.rto = data[RTO_W-1:0];
		default:        st.max_retry = data[RETRY_W-1:0];
		endcase
		// Either window register reloads window and release limit
		if (idx == REG_SENDER_WND || idx == REG_RECV_WND) begin
			st.window = (st.sender_wnd < st.recv_wnd_init) ? st.sender_wnd : st.recv_wnd_init;
			st.limit = st.base_seq + SEQ_W'(st.window);
		end
	endfunction

	function automatic win_result_t advance_sender(inout win_state_t st, input event_t ev);
		win_result_t res;
		logic [SEQ_W-1:0] in_flight, room, ack_dist;
		res.action = ACT_NONE;
		res.tx_seq = '0;
		in_flight = st.next_seq - st.base_seq;
		if (st.aborted) begin
			res.action = ACT_ABORT;
		end else begin
			case (ev.cmd)
			CMD_SEND: begin
				// Admit while the release limit leaves room
				room = st.limit - st.base_seq;
				if (in_flight < room) begin
					if (in_flight == '0)
						st.timer = timer_load(st);
					res.action = ACT_TX_NEW;
					res.tx_seq = st.next_seq;
					st.next_seq = st.next_seq + SEQ_W'(1);
				end else begin
					res.action = ACT_REFUSED;
				end
			end
			CMD_ACK: begin
				ack_dist = ev.ack_seq - st.base_seq;
				if (ack_dist != '0 && ack_dist <= in_flight) begin
					// New cumulative ACK: advance base, reopen window
					st.acked = st.acked + CNT_W'(ack_dist);
					st.base_seq = ev.ack_seq;
					st.timer = timer_load(st);
					st.window = (st.sender_wnd < ev.recv_wnd) ? st.sender_wnd : ev.recv_wnd;
					st.limit = st.base_seq + SEQ_W'(st.window);
					st.retries = '0;
					st.dups = '0;
				end else if (ack_dist == '0 && in_flight != '0) begin
					// Duplicate: the third one fast-retransmits the base
					if (st.dups < DUP_MAX)
						st.dups = st.dups + DUP_W'(1);
					if (st.dups == DUP_TRIGGER) begin
						res.action = ACT_FAST;
						res.tx_seq = st.base_seq;
						st.timer = timer_load(st);
						st.fast_retx = st.fast_retx + CNT_W'(1);
						if (st.retries < RETRY_MAX)
							st.retries = st.retries + RETRY_W'(1);
					end
				end
			end
			CMD_TICK: begin
				// Run the timer only while packets are outstanding
				if (in_flight != '0) begin
					if (st.timer > RTO_W'(1)) begin
						st.timer = st.timer - RTO_W'(1);
					end else begin
						if (st.retries < RETRY_MAX)
							st.retries = st.retries + RETRY_W'(1);
						st.timeouts = st.timeouts + CNT_W'(1);
						if (st.retries >= st.max_retry) begin
							st.aborted = 1'b1;
							res.action = ACT_ABORT;
							st.timer = '0;
						end else begin
							res.action = ACT_TIMEOUT;
							res.tx_seq = st.base_seq;
							st.timer = timer_load(st);
						end
					end
				end
			end
			default: ;
			endcase
		end
		res.base_now = st.base_seq;
		res.next_now = st.next_seq;
		res.window_now = st.window;
		res.timeouts_now = st.timeouts;
		res.fast_retx_now = st.fast_retx;
		res.acked_now = st.acked;
		return res;
	endfunction

	// ---------------- stimulus planning ----------------

	function automatic event_t make_event(input logic [CMD_W-1:0] cmd,
			input logic [SEQ_W-1:0] ack_seq, input logic [WND_W-1:0] recv_wnd);
		event_t ev;
		ev.cmd = cmd;
		ev.ack_seq = ack_seq;
		ev.recv_wnd = recv_wnd;
		return ev;
	endfunction

	function automatic logic [WND_W-1:0] pick_rwnd();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2: return r[WND_W-1:0];
		default: return WND_W'($urandom_range(1, 12));
		endcase
	endfunction

	// Queue one event; outside the closing phase swap an aborting tick for
	// an ACK of everything sent, which is always valid at that point
	task automatic push_event(input event_t ev);
		win_state_t probe;
		win_result_t res;
		probe = plan_st;
		res = advance_sender(probe, ev);
		if (res.action == ACT_ABORT && !allow_abort) begin
			ev = make_event(CMD_ACK, plan_st.next_seq, pick_rwnd());
			probe = plan_st;
			res = advance_sender(probe, ev);
		end
		plan_st = probe;
		event_q.push_back(ev);
		events_planned++;
	endtask

	task automatic queue_random_event();
		event_t ev;
		logic [SEQ_W-1:0] in_flight;
		logic [31:0] r;
		int unsigned pick, n;
		in_flight = plan_st.next_seq - plan_st.base_seq;
		r = $urandom;
		ev = make_event(CMD_TICK, $urandom, r[WND_W-1:0]);
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			// Noise: reserved command, wild ACK, or ACK behind the base
			case (pick % 3)
			0: ev.cmd = CMD_RESERVED;
			1: ev.cmd = CMD_ACK;
			default: begin
				ev.cmd = CMD_ACK;
				ev.ack_seq = plan_st.base_seq - $urandom_range(1, 1000);
			end
			endcase
			push_event(ev);
		end else if (pick < 40) begin
			ev.cmd = CMD_SEND;
			push_event(ev);
		end else if (pick < 62 && in_flight != '0) begin
			ev.cmd = CMD_ACK;
			ev.ack_seq = plan_st.base_seq + $urandom_range(1, in_flight);
			ev.recv_wnd = pick_rwnd();
			push_event(ev);
		end else if (pick < 76 && in_flight != '0) begin
			// Burst of duplicate ACKs on the base
			n = $urandom_range(1, 4);
			repeat (n) begin
				r = $urandom;
				push_event(make_event(CMD_ACK, plan_st.base_seq, r[WND_W-1:0]));
			end
		end else begin
			push_event(ev);
		end
	endtask

	// ---------------- register channel ----------------

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(model_st, idx, data);
		apply_reg(plan_st, idx, data);
		cfg_writes++;
	endtask

	task automatic program_regs(input logic [CFG_DAT_W-1:0] sw, input logic [CFG_DAT_W-1:0] rw,
			input logic [CFG_DAT_W-1:0] rto, input logic [CFG_DAT_W-1:0] mr);
		write_reg(REG_SENDER_WND, sw);
		write_reg(REG_RECV_WND, rw);
		write_reg(REG_RTO, rto);
		write_reg(REG_MAX_RETRY, mr);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold until every queued event is through and every result is in
	task automatic wait_idle();
		@(negedge clk);
		while (event_q.size() != 0 || event_held || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------- event driver ----------------

	// Present the next event, or idle for a burst
	always @(negedge clk) begin
		if (!event_held) begin
			if (src_gap != 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (event_q.size() != 0) begin
				held_event = event_q.pop_front();
				event_held = 1'b1;
				s_tvalid <= 1'b1;
				s_tdata <= {held_event.recv_wnd, held_event.ack_seq};
				s_tuser <= held_event.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Predict the result of each accepted transfer
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_results.push_back(advance_sender(model_st, held_event));
			event_held = 1'b0;
			events_accepted++;
			if (!quiet && $urandom_range(0, 5) == 0)
				src_gap = $urandom_range(1, 4);
		end
	end

	// ---------------- result monitor ----------------

	// Stall the result stream in bursts
	always @(negedge clk) begin
		if (sink_stall != 0) begin
			sink_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0)
				sink_stall = $urandom_range(1, 4);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d %s: expected %h, got %h", results_checked, name, want, got);
		end
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		win_result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing predicted: action %0d",
						results_checked, m_tuser);
			end else begin
				want = expected_results.pop_front();
				check_field("action", 32'(want.action), 32'(m_tuser));
				check_field("tx_seq", want.tx_seq, m_tdata[31:0]);
				check_field("base_now", want.base_now, m_tdata[63:32]);
				check_field("next_now", want.next_now, m_tdata[95:64]);
				check_field("window_now", 32'(want.window_now), 32'(m_tdata[111:96]));
				check_field("timeouts_now", want.timeouts_now, m_tdata[143:112]);
				check_field("fast_retx_now", want.fast_retx_now, m_tdata[175:144]);
				check_field("acked_now", want.acked_now, m_tdata[207:176]);
			end
			action_seen[m_tuser]++;
			results_checked++;
		end
	end

	// End the run when no transfer moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", stall_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles++;
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		int unsigned goal;
		logic [31:0] r;
		model_st = reset_state();
		plan_st = reset_state();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default registers: idle cases, duplicates, zero window, stale ACK
		push_event(make_event(CMD_TICK, '0, '0));
		push_event(make_event(CMD_ACK, '0, '0));
		push_event(make_event(CMD_RESERVED, '1, '1));
		push_event(make_event(CMD_SEND, '0, '0));
		push_event(make_event(CMD_ACK, '1, '1));
		push_event(make_event(CMD_SEND, '1, '1));
		push_event(make_event(CMD_SEND, '0, '1));
		repeat (4) push_event(make_event(CMD_ACK, '0, 16'd7));
		push_event(make_event(CMD_ACK, 32'd2, '0));
		push_event(make_event(CMD_SEND, '0, '0));
		push_event(make_event(CMD_ACK, 32'd3, '1));
		push_event(make_event(CMD_SEND, '0, '0));
		push_event(make_event(CMD_ACK, 32'd2, 16'd4));
		wait_idle();

		// Zero timeout: restart the timer by an ACK, then expire twice
		program_regs(20'd65535, 20'd65535, 20'd0, 20'd255);
		push_event(make_event(CMD_SEND, '0, '0));
		push_event(make_event(CMD_ACK, 32'd4, '1));
		push_event(make_event(CMD_TICK, '1, '1));
		push_event(make_event(CMD_TICK, '0, '0));
		push_event(make_event(CMD_ACK, 32'd5, 16'd5));
		push_event(make_event(CMD_TICK, '0, '0));
		wait_idle();

		// Random phases under a range of register settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 4) begin
				r = $urandom;
				phase_sw[p] = r[CFG_DAT_W-1:0];
				r = $urandom;
				phase_rw[p] = r[CFG_DAT_W-1:0];
				phase_rto[p] = CFG_DAT_W'($urandom_range(0, 12));
				r = $urandom;
				phase_mr[p] = r[CFG_DAT_W-1:0];
			end
			quiet = ($urandom_range(0, 3) == 0);
			program_regs(phase_sw[p], phase_rw[p], phase_rto[p], phase_mr[p]);
			goal = events_planned + PHASE_EVENTS;
			while (events_planned < goal)
				queue_random_event();
			wait_idle();
		end

		// Closing phase: zero retry limit, no idling, abort allowed
		quiet = 1'b1;
		allow_abort = 1'b1;
		program_regs(20'd16, 20'd16, 20'd2, 20'd0);
		push_event(make_event(CMD_SEND, '0, '0));
		push_event(make_event(CMD_ACK, plan_st.next_seq, 16'd16));
		goal = events_planned + 70;
		while (events_planned < goal)
			queue_random_event();
		// Force the abort if the random part missed it
		push_event(make_event(CMD_SEND, '0, '0));
		push_event(make_event(CMD_ACK, plan_st.next_seq, 16'd16));
		push_event(make_event(CMD_SEND, '0, '0));
		push_event(make_event(CMD_TICK, '0, '0));
		push_event(make_event(CMD_TICK, '0, '0));
		wait_idle();

		// Register writes still land after the abort
		write_reg(REG_SENDER_WND, 20'd3);
		write_reg(REG_RTO, 20'd5);
		@(negedge clk);
		cfg_valid <= 1'b0;
		goal = events_planned + 12;
		while (events_planned < goal)
			queue_random_event();
		wait_idle();
		repeat (10) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0d predicted results never arrived", expected_results.size());
			mismatches += expected_results.size();
		end
		$display("Run: %0d events accepted, %0d results checked, %0d register writes",
			events_accepted, results_checked, cfg_writes);
		$display("Actions: new %0d, timeout %0d, fast %0d, abort %0d, refused %0d, none %0d",
			action_seen[ACT_TX_NEW], action_seen[ACT_TIMEOUT], action_seen[ACT_FAST],
			action_seen[ACT_ABORT], action_seen[ACT_REFUSED], action_seen[ACT_NONE]);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/swnd_pkg.sv
rtl/core/sliding_window_sender.sv
tb/sv/tb_sliding_window_sender.sv
